FILE: rtl/dsrv_pkg.sv
package dsrv_pkg;

   localparam int NUM_NODES_DEFAULT = 3;
   localparam int NODE_IDX_W        = 3;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd3;
   localparam logic [31:0] IDENT_RESET     = 32'h4757_3031;

   // service identifiers
   localparam logic [7:0] SID_SESSION = 8'h10;
   localparam logic [7:0] SID_READ    = 8'h22;
   localparam logic [7:0] SID_REPORT  = 8'h19;
   localparam logic [7:0] SID_CLEAR   = 8'h14;

   // positive response codes
   localparam logic [7:0] POS_SESSION = 8'h50;
   localparam logic [7:0] POS_READ    = 8'h62;
   localparam logic [7:0] POS_REPORT  = 8'h59;
   localparam logic [7:0] POS_CLEAR   = 8'h54;

   // negative response
   localparam logic [7:0] NEG_RSP     = 8'h7F;
   localparam logic [7:0] NRC_SERVICE = 8'h11;
   localparam logic [7:0] NRC_SUBFUNC = 8'h12;
   localparam logic [7:0] NRC_LENGTH  = 8'h13;
   localparam logic [7:0] NRC_RANGE   = 8'h31;

   // sub-functions and data ids
   localparam logic [7:0] SESS_DEFAULT = 8'h01;
   localparam logic [7:0] SESS_EXTENDED = 8'h03;
   localparam logic [7:0] SUB_REPORT_ALL  = 8'h0A;
   localparam logic [7:0] SUB_REPORT_MASK = 8'h02;
   localparam logic [7:0] ID_IDENT_HI = 8'hF1;
   localparam logic [7:0] ID_IDENT_LO = 8'h90;
   localparam logic [7:0] ID_NODE_HI  = 8'h04;
   localparam logic [7:0] GROUP_ALL   = 8'hFF;
   localparam logic [7:0] STATUS_AVAIL = 8'hFF;
   localparam logic [7:0] DTC_HIGH    = 8'hC4;
   localparam logic [7:0] DTC_LOW     = 8'h00;

   localparam logic [7:0] ST_FAILED    = 8'h01;
   localparam logic [7:0] ST_CONFIRMED = 8'h08;
   localparam logic [7:0] COUNT_MAX    = 8'hFF;

   localparam logic [0:0] CSR_THRESHOLD = 1'b0;
   localparam logic [0:0] CSR_IDENT     = 1'b1;

   typedef enum logic [1:0] {
      OP_REQUEST   = 2'd0,
      OP_LOST      = 2'd1,
      OP_RECOVERED = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      K_FAIL,
      K_RECOVER,
      K_WIPE,
      K_NEG,
      K_SESSION,
      K_IDENT,
      K_NODE,
      K_REPORT,
      K_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [7:0]            sid;
      logic [7:0]            b1;
      logic [7:0]            b2;
      logic [7:0]            code;
      logic [NODE_IDX_W-1:0] node;
      logic                  masked;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HEAD,
      BK_NODES
   } back_state_type;

endpackage

FILE: rtl/diag_request_server_with_fault_codes.sv
// Diagnostic responder for NUM_NODES monitored nodes. Each request is either
// a node event (comm lost, recovered, clear all) or a diagnostic request that
// is answered as a stream of response bytes, one per cycle on the rsp channel
// while rsp_ready is high, with rsp_resp_last on the final byte; zero-length
// requests and events give no bytes. Requests are classified on entry and
// held in a two-entry queue; the back end takes one every cycle it is free.
// An event occupies the back end only for its dequeue, a response until its
// last byte is loaded into the output register, and a masked fault report
// also steps over each node the mask filters out ahead of the last node it
// lists. The single-byte output register holds one byte at a time; a report
// over three nodes is the longest answer. csr_ready is always high.
module diag_request_server_with_fault_codes #(
   parameter int NUM_NODES = dsrv_pkg::NUM_NODES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_node_index,
   input  logic [15:0] req_req_length,
   input  logic [7:0]  req_req_byte0,
   input  logic [7:0]  req_req_byte1,
   input  logic [7:0]  req_req_byte2,
   input  logic [7:0]  req_req_byte3,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_resp_byte,
   output logic        rsp_resp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [7:0]        threshold_ff;
   logic [31:0]       ident_ff;
   logic              push;
   logic              pop;
   logic              q_full;
   logic              q_valid;
   dsrv_pkg::cmd_type front_cmd;
   dsrv_pkg::cmd_type head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= dsrv_pkg::THRESHOLD_RESET;
         ident_ff     <= dsrv_pkg::IDENT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            dsrv_pkg::CSR_THRESHOLD: threshold_ff <= csr_data[7:0];
            default:                 ident_ff     <= csr_data;
         endcase
      end
   end

   dsrv_front #(
      .NUM_NODES(NUM_NODES)
   ) u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_node_index (req_node_index),
      .req_length     (req_req_length),
      .req_byte0      (req_req_byte0),
      .req_byte1      (req_req_byte1),
      .req_byte2      (req_req_byte2),
      .req_byte3      (req_req_byte3),
      .queue_full     (q_full),
      .push           (push),
      .cmd            (front_cmd)
   );

   dsrv_queue #(
      .DEPTH(dsrv_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (q_valid),
      .full      (q_full)
   );

   dsrv_back #(
      .NUM_NODES(NUM_NODES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (head_cmd),
      .pop               (pop),
      .confirm_threshold (threshold_ff),
      .ecu_ident         (ident_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_resp_byte     (rsp_resp_byte),
      .rsp_resp_last     (rsp_resp_last)
   );

endmodule

FILE: rtl/dsrv_front.sv
module dsrv_front #(
   parameter int NUM_NODES = dsrv_pkg::NUM_NODES_DEFAULT
) (
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [1:0]        req_node_index,
   input  logic [15:0]       req_length,
   input  logic [7:0]        req_byte0,
   input  logic [7:0]        req_byte1,
   input  logic [7:0]        req_byte2,
   input  logic [7:0]        req_byte3,
   input  logic              queue_full,
   output logic              push,
   output dsrv_pkg::cmd_type cmd
);

   logic keep;
   logic node_ok;

   assign node_ok   = {2'b00, req_node_index} < 4'(NUM_NODES);
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full && keep;

   always_comb begin
      cmd        = '0;
      keep       = 1'b0;
      cmd.sid    = req_byte0;
      cmd.b1     = req_byte1;
      cmd.b2     = req_byte2;
      cmd.node   = {1'b0, req_node_index};
      cmd.kind   = dsrv_pkg::K_NEG;
      cmd.code   = dsrv_pkg::NRC_SERVICE;
      unique case (dsrv_pkg::op_type'(req_opcode))
         dsrv_pkg::OP_LOST: begin
            keep     = node_ok;
            cmd.kind = dsrv_pkg::K_FAIL;
         end
         dsrv_pkg::OP_RECOVERED: begin
            keep     = node_ok;
            cmd.kind = dsrv_pkg::K_RECOVER;
         end
         dsrv_pkg::OP_CLEAR: begin
            keep     = 1'b1;
            cmd.kind = dsrv_pkg::K_WIPE;
         end
         default: begin
            // zero length request gives nothing
            keep = (req_length != 16'd0);
            unique case (req_byte0)
               dsrv_pkg::SID_SESSION: begin
                  if (req_length != 16'd2) begin
                     cmd.code = dsrv_pkg::NRC_LENGTH;
                  end else if (req_byte1 != dsrv_pkg::SESS_DEFAULT &&
                               req_byte1 != dsrv_pkg::SESS_EXTENDED) begin
                     cmd.code = dsrv_pkg::NRC_SUBFUNC;
                  end else begin
                     cmd.kind = dsrv_pkg::K_SESSION;
                  end
               end
               dsrv_pkg::SID_READ: begin
                  if (req_length != 16'd3) begin
                     cmd.code = dsrv_pkg::NRC_LENGTH;
                  end else if (req_byte1 == dsrv_pkg::ID_IDENT_HI &&
                               req_byte2 == dsrv_pkg::ID_IDENT_LO) begin
                     cmd.kind = dsrv_pkg::K_IDENT;
                  end else if (req_byte1 == dsrv_pkg::ID_NODE_HI &&
                               req_byte2 < 8'(NUM_NODES)) begin
                     cmd.kind = dsrv_pkg::K_NODE;
                     cmd.node = req_byte2[dsrv_pkg::NODE_IDX_W-1:0];
                  end else begin
                     cmd.code = dsrv_pkg::NRC_RANGE;
                  end
               end
               dsrv_pkg::SID_REPORT: begin
                  if (req_length != 16'd2 && req_length != 16'd3) begin
                     cmd.code = dsrv_pkg::NRC_LENGTH;
                  end else if (req_byte1 == dsrv_pkg::SUB_REPORT_ALL) begin
                     cmd.kind = dsrv_pkg::K_REPORT;
                  end else if (req_byte1 == dsrv_pkg::SUB_REPORT_MASK) begin
                     cmd.kind   = dsrv_pkg::K_REPORT;
                     cmd.masked = 1'b1;
                  end else begin
                     cmd.code = dsrv_pkg::NRC_SUBFUNC;
                  end
               end
               dsrv_pkg::SID_CLEAR: begin
                  if (req_length != 16'd4) begin
                     cmd.code = dsrv_pkg::NRC_LENGTH;
                  end else if (req_byte1 == dsrv_pkg::GROUP_ALL &&
                               req_byte2 == dsrv_pkg::GROUP_ALL &&
                               req_byte3 == dsrv_pkg::GROUP_ALL) begin
                     cmd.kind = dsrv_pkg::K_CLEAR;
                  end else begin
                     cmd.code = dsrv_pkg::NRC_RANGE;
                  end
               end
               default: begin
                  cmd.code = dsrv_pkg::NRC_SERVICE;
               end
            endcase
         end
      endcase
   end

endmodule

FILE: rtl/dsrv_queue.sv
module dsrv_queue #(
   parameter int DEPTH = dsrv_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dsrv_pkg::cmd_type push_cmd,
   input  logic              pop,
   output dsrv_pkg::cmd_type head_cmd,
   output logic              not_empty,
   output logic              full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsrv_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/dsrv_back.sv
module dsrv_back #(
   parameter int NUM_NODES = dsrv_pkg::NUM_NODES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  dsrv_pkg::cmd_type q_cmd,
   output logic              pop,
   input  logic [7:0]        confirm_threshold,
   input  logic [31:0]       ecu_ident,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_resp_byte,
   output logic              rsp_resp_last
);

   localparam int NODE_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

   dsrv_pkg::back_state_type state_ff, state_in;
   dsrv_pkg::cmd_type        cmd_ff, cmd_in;
   logic [2:0]               pos_ff, pos_in;
   logic [NODE_W-1:0]        node_ff, node_in;
   logic [NUM_NODES-1:0]     match_ff, match_in;
   logic [7:0]               status_ff [NUM_NODES];
   logic [7:0]               status_in [NUM_NODES];
   logic [7:0]               count_ff  [NUM_NODES];
   logic [7:0]               count_in  [NUM_NODES];
   logic                     rsp_valid_ff;
   logic [7:0]               rsp_byte_ff;
   logic                     rsp_last_ff;

   logic              out_free;
   logic              out_load;
   logic [7:0]        byte_v;
   logic              last_v;
   logic              more;
   logic [NODE_W-1:0] hn;
   logic [7:0]        cnt_next;
   logic [7:0]        cur_status;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_resp_byte = rsp_byte_ff;
   assign rsp_resp_last = rsp_last_ff;
   assign hn            = q_cmd.node[NODE_W-1:0];
   assign cnt_next      = (count_ff[hn] == dsrv_pkg::COUNT_MAX) ? count_ff[hn]
                                                                : count_ff[hn] + 8'd1;
   assign cur_status    = status_ff[node_ff];

   // any listed node after the cursor
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < NUM_NODES; i++) begin
         if (i > int'(node_ff) && match_ff[i]) begin
            more = 1'b1;
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      pos_in    = pos_ff;
      node_in   = node_ff;
      match_in  = match_ff;
      status_in = status_ff;
      count_in  = count_ff;
      pop       = 1'b0;
      out_load  = 1'b0;
      byte_v    = 8'h00;
      last_v    = 1'b0;
      unique case (state_ff)
         dsrv_pkg::BK_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               pos_in = '0;
               unique case (q_cmd.kind)
                  dsrv_pkg::K_FAIL: begin
                     count_in[hn]  = cnt_next;
                     status_in[hn] = status_ff[hn] | dsrv_pkg::ST_FAILED |
                                     ((cnt_next >= confirm_threshold) ?
                                      dsrv_pkg::ST_CONFIRMED : 8'h00);
                  end
                  dsrv_pkg::K_RECOVER: begin
                     status_in[hn] = status_ff[hn] & ~dsrv_pkg::ST_FAILED;
                     count_in[hn]  = 8'h00;
                  end
                  dsrv_pkg::K_WIPE: begin
                     for (int i = 0; i < NUM_NODES; i++) begin
                        status_in[i] = 8'h00;
                        count_in[i]  = 8'h00;
                     end
                  end
                  dsrv_pkg::K_CLEAR: begin
                     for (int i = 0; i < NUM_NODES; i++) begin
                        status_in[i] = 8'h00;
                        count_in[i]  = 8'h00;
                     end
                     state_in = dsrv_pkg::BK_HEAD;
                  end
                  dsrv_pkg::K_REPORT: begin
                     // status is frozen while the report streams out
                     for (int i = 0; i < NUM_NODES; i++) begin
                        match_in[i] = !q_cmd.masked || ((status_ff[i] & q_cmd.b2) != 8'h00);
                     end
                     state_in = dsrv_pkg::BK_HEAD;
                  end
                  default: begin
                     state_in = dsrv_pkg::BK_HEAD;
                  end
               endcase
            end
         end
         dsrv_pkg::BK_HEAD: begin
            unique case (cmd_ff.kind)
               dsrv_pkg::K_SESSION: begin
                  byte_v = (pos_ff == 3'd0) ? dsrv_pkg::POS_SESSION : cmd_ff.b1;
                  last_v = (pos_ff == 3'd1);
               end
               dsrv_pkg::K_IDENT: begin
                  unique case (pos_ff)
                     3'd0:    byte_v = dsrv_pkg::POS_READ;
                     3'd1:    byte_v = cmd_ff.b1;
                     3'd2:    byte_v = cmd_ff.b2;
                     3'd3:    byte_v = ecu_ident[31:24];
                     3'd4:    byte_v = ecu_ident[23:16];
                     3'd5:    byte_v = ecu_ident[15:8];
                     default: byte_v = ecu_ident[7:0];
                  endcase
                  last_v = (pos_ff == 3'd6);
               end
               dsrv_pkg::K_NODE: begin
                  unique case (pos_ff)
                     3'd0:    byte_v = dsrv_pkg::POS_READ;
                     3'd1:    byte_v = cmd_ff.b1;
                     3'd2:    byte_v = cmd_ff.b2;
                     default: byte_v = status_ff[cmd_ff.node[NODE_W-1:0]] &
                                       dsrv_pkg::ST_FAILED;
                  endcase
                  last_v = (pos_ff == 3'd3);
               end
               dsrv_pkg::K_REPORT: begin
                  unique case (pos_ff)
                     3'd0:    byte_v = dsrv_pkg::POS_REPORT;
                     3'd1:    byte_v = cmd_ff.b1;
                     default: byte_v = dsrv_pkg::STATUS_AVAIL;
                  endcase
                  last_v = (pos_ff == 3'd2) && (match_ff == '0);
               end
               dsrv_pkg::K_CLEAR: begin
                  byte_v = dsrv_pkg::POS_CLEAR;
                  last_v = 1'b1;
               end
               default: begin
                  unique case (pos_ff)
                     3'd0:    byte_v = dsrv_pkg::NEG_RSP;
                     3'd1:    byte_v = cmd_ff.sid;
                     default: byte_v = cmd_ff.code;
                  endcase
                  last_v = (pos_ff == 3'd2);
               end
            endcase
            if (out_free) begin
               out_load = 1'b1;
               pos_in   = pos_ff + 3'd1;
               if (last_v) begin
                  state_in = dsrv_pkg::BK_IDLE;
               end else if (cmd_ff.kind == dsrv_pkg::K_REPORT && pos_ff == 3'd2) begin
                  state_in = dsrv_pkg::BK_NODES;
                  node_in  = '0;
                  pos_in   = '0;
               end
            end
         end
         dsrv_pkg::BK_NODES: begin
            unique case (pos_ff[1:0])
               2'd0:    byte_v = dsrv_pkg::DTC_HIGH;
               2'd1:    byte_v = 8'(node_ff);
               2'd2:    byte_v = dsrv_pkg::DTC_LOW;
               default: byte_v = cur_status;
            endcase
            last_v = (pos_ff[1:0] == 2'd3) && !more;
            if (!match_ff[node_ff]) begin
               // node filtered out by the mask, step over it
               node_in = node_ff + 1'b1;
               pos_in  = '0;
            end else if (out_free) begin
               out_load = 1'b1;
               pos_in   = pos_ff + 3'd1;
               if (pos_ff[1:0] == 2'd3) begin
                  pos_in  = '0;
                  node_in = node_ff + 1'b1;
                  if (!more) begin
                     state_in = dsrv_pkg::BK_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = dsrv_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsrv_pkg::BK_IDLE;
         pos_ff       <= '0;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_NODES; i++) begin
            status_ff[i] <= 8'h00;
            count_ff[i]  <= 8'h00;
         end
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         node_ff   <= node_in;
         status_ff <= status_in;
         count_ff  <= count_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      match_ff <= match_in;
      if (out_load) begin
         rsp_byte_ff <= byte_v;
         rsp_last_ff <= last_v;
      end
   end

endmodule

FILE: tb/tb.sv
module tb;
   import dsrv_pkg::*;

   localparam int N_NODES       = NUM_NODES_DEFAULT;
   localparam int CYCLE_LIMIT   = 800000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } resp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = OP_REQUEST;
   logic [1:0]  req_node_index = 2'd0;
   logic [15:0] req_req_length = 16'd0;
   logic [7:0]  req_req_byte0 = 8'h00;
   logic [7:0]  req_req_byte1 = 8'h00;
   logic [7:0]  req_req_byte2 = 8'h00;
   logic [7:0]  req_req_byte3 = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_resp_byte;
   logic        rsp_resp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = CSR_THRESHOLD;
   logic [31:0] csr_data = 32'd0;

   // predicted block state
   logic [7:0]  thr_cfg = THRESHOLD_RESET;
   logic [31:0] ident_cfg = IDENT_RESET;
   logic [7:0]  node_status [N_NODES];
   logic [7:0]  node_count [N_NODES];
   logic [1:0]  sess_mode = SESS_DEFAULT[1:0];

   logic [7:0]    answer [$];
   resp_beat_type pending_resp [$];

   int mismatches = 0;
   int cycle_count = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;
   int stall_left = 0;

   diag_request_server_with_fault_codes dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_node_index (req_node_index),
      .req_req_length (req_req_length),
      .req_req_byte0  (req_req_byte0),
      .req_req_byte1  (req_req_byte1),
      .req_req_byte2  (req_req_byte2),
      .req_req_byte3  (req_req_byte3),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_resp_byte  (rsp_resp_byte),
      .rsp_resp_last  (rsp_resp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always #6 clock = ~clock;

   // mostly short, now and then long
   function automatic int gap_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic wipe_faults();
      for (int i = 0; i < N_NODES; i++) begin
         node_status[i] = 8'h00;
         node_count[i]  = 8'h00;
      end
   endtask

   task automatic add_negative(input logic [7:0] sid, input logic [7:0] code);
      answer.push_back(NEG_RSP);
      answer.push_back(sid);
      answer.push_back(code);
   endtask

   task automatic predict_response(input op_type op, input logic [1:0] node,
         input logic [15:0] len, input logic [7:0] sid, input logic [7:0] b1,
         input logic [7:0] b2, input logic [7:0] b3);
      logic masked;
      answer.delete();
      if (op == OP_CLEAR) begin
         wipe_faults();
      end else if (op != OP_REQUEST) begin
         if (node < N_NODES) begin
            if (op == OP_LOST) begin
               node_status[node] = node_status[node] | ST_FAILED;
               if (node_count[node] != COUNT_MAX) node_count[node] = node_count[node] + 8'd1;
               if (node_count[node] >= thr_cfg)
                  node_status[node] = node_status[node] | ST_CONFIRMED;
            end else begin
               node_status[node] = node_status[node] & ~ST_FAILED;
               node_count[node]  = 8'h00;
            end
         end
      end else if (len != 16'd0) begin
         case (sid)
            SID_SESSION: begin
               if (len != 16'd2) add_negative(sid, NRC_LENGTH);
               else if (b1 != SESS_DEFAULT && b1 != SESS_EXTENDED)
                  add_negative(sid, NRC_SUBFUNC);
               else begin
                  sess_mode = b1[1:0];
                  answer.push_back(POS_SESSION);
                  answer.push_back(b1);
               end
            end
            SID_READ: begin
               if (len != 16'd3) add_negative(sid, NRC_LENGTH);
               else if (b1 == ID_IDENT_HI && b2 == ID_IDENT_LO) begin
                  answer.push_back(POS_READ);
                  answer.push_back(b1);
                  answer.push_back(b2);
                  answer.push_back(ident_cfg[31:24]);
                  answer.push_back(ident_cfg[23:16]);
                  answer.push_back(ident_cfg[15:8]);
                  answer.push_back(ident_cfg[7:0]);
               end else if (b1 == ID_NODE_HI && b2 < N_NODES) begin
                  answer.push_back(POS_READ);
                  answer.push_back(b1);
                  answer.push_back(b2);
                  answer.push_back(node_status[b2] & ST_FAILED);
               end else add_negative(sid, NRC_RANGE);
            end
            SID_REPORT: begin
               if (len != 16'd2 && len != 16'd3) add_negative(sid, NRC_LENGTH);
               else if (b1 != SUB_REPORT_ALL && b1 != SUB_REPORT_MASK)
                  add_negative(sid, NRC_SUBFUNC);
               else begin
                  masked = (b1 == SUB_REPORT_MASK);
                  answer.push_back(POS_REPORT);
                  answer.push_back(b1);
                  answer.push_back(STATUS_AVAIL);
                  for (int i = 0; i < N_NODES; i++) begin
                     if (!masked || (node_status[i] & b2) != 8'h00) begin
                        answer.push_back(DTC_HIGH);
                        answer.push_back(8'(i));
                        answer.push_back(DTC_LOW);
                        answer.push_back(node_status[i]);
                     end
                  end
               end
            end
            SID_CLEAR: begin
               if (len != 16'd4) add_negative(sid, NRC_LENGTH);
               else if (b1 != GROUP_ALL || b2 != GROUP_ALL || b3 != GROUP_ALL)
                  add_negative(sid, NRC_RANGE);
               else begin
                  wipe_faults();
                  answer.push_back(POS_CLEAR);
               end
            end
            default: add_negative(sid, NRC_SERVICE);
         endcase
      end
      for (int i = 0; i < answer.size(); i++)
         pending_resp.push_back({answer[i], i == answer.size() - 1});
   endtask

   task automatic send_item(input op_type op, input logic [1:0] node,
         input logic [15:0] len, input logic [7:0] b0, input logic [7:0] b1,
         input logic [7:0] b2, input logic [7:0] b3);
      int gap;
      gap = ($urandom_range(0, 99) < req_gap_pct) ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_node_index <= node;
      req_req_length <= len;
      req_req_byte0  <= b0;
      req_req_byte1  <= b1;
      req_req_byte2  <= b2;
      req_req_byte3  <= b3;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_response(op, node, len, b0, b1, b2, b3);
   endtask

   // events leave no response, so give the back end time after the last byte
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_resp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [7:0] threshold, input logic [31:0] ident);
      csr_valid <= 1'b1;
      csr_index <= CSR_THRESHOLD;
      csr_data  <= {24'd0, threshold};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      thr_cfg = threshold;
      csr_index <= CSR_IDENT;
      csr_data  <= ident;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      ident_cfg = ident;
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int pick;
      logic [1:0] node;
      logic [7:0] r1, r2, r3;
      logic [15:0] len;
      pick = $urandom_range(0, 99);
      node = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, N_NODES - 1));
      r1 = 8'($urandom);
      r2 = 8'($urandom);
      r3 = 8'($urandom);
      len = 16'($urandom);
      if (pick < 30) send_item(OP_LOST, node, len, r1, r2, r3, 8'($urandom));
      else if (pick < 40) send_item(OP_RECOVERED, node, len, r1, r2, r3, 8'($urandom));
      else if (pick < 42) send_item(OP_CLEAR, node, len, r1, r2, r3, 8'($urandom));
      else if (pick < 55) begin
         if ($urandom_range(0, 4) != 0) r1 = $urandom_range(0, 1) ? SESS_DEFAULT : SESS_EXTENDED;
         send_item(OP_REQUEST, node, 16'd2, SID_SESSION, r1, r2, r3);
      end else if (pick < 70) begin
         case ($urandom_range(0, 3))
            0: begin r1 = ID_IDENT_HI; r2 = ID_IDENT_LO; end
            1, 2: begin r1 = ID_NODE_HI; r2 = 8'($urandom_range(0, N_NODES)); end
            default: ;
         endcase
         send_item(OP_REQUEST, node, 16'd3, SID_READ, r1, r2, r3);
      end else if (pick < 87) begin
         if ($urandom_range(0, 7) != 0) r1 = $urandom_range(0, 1) ? SUB_REPORT_ALL : SUB_REPORT_MASK;
         if ($urandom_range(0, 1) == 0)
            r2 = $urandom_range(0, 1) ? ST_FAILED : ST_CONFIRMED;
         send_item(OP_REQUEST, node, 16'($urandom_range(2, 3)), SID_REPORT, r1, r2, r3);
      end else if (pick < 89) begin
         if ($urandom_range(0, 1) == 0) begin
            r1 = GROUP_ALL; r2 = GROUP_ALL; r3 = GROUP_ALL;
         end
         send_item(OP_REQUEST, node, 16'd4, SID_CLEAR, r1, r2, r3);
      end else begin
         // noise: any service byte, any length
         if ($urandom_range(0, 1) == 0) len = 16'($urandom_range(0, 5));
         send_item(OP_REQUEST, node, len, 8'($urandom), r1, r2, r3);
      end
   endtask

   task automatic test_directed();
      req_gap_pct = 30;
      rsp_stall_pct = 30;
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_SESSION, SESS_EXTENDED, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd3, 16'd2, SID_SESSION, SESS_DEFAULT, 8'hFF, 8'hFF);
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_SESSION, 8'h02, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_SESSION, SESS_DEFAULT, 8'h00, 8'h00);
      // request bytes are ignored on events
      send_item(OP_LOST, 2'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_LOST, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_LOST, 2'd0, 16'd2, SID_READ, 8'h00, 8'h00, 8'h00);
      send_item(OP_LOST, 2'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_LOST, 2'd3, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_READ, ID_IDENT_HI, ID_IDENT_LO, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_READ, ID_NODE_HI, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_READ, ID_NODE_HI, 8'h03, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_READ, ID_IDENT_HI, ID_IDENT_LO, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_REPORT, SUB_REPORT_ALL, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_REPORT, SUB_REPORT_MASK, ST_CONFIRMED, 8'h00);
      // mask taken from the third byte even on a two-byte request
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_REPORT, SUB_REPORT_MASK, ST_FAILED, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_REPORT, 8'h01, 8'hFF, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'hFFFF, SID_REPORT, SUB_REPORT_ALL, 8'h00, 8'h00);
      send_item(OP_RECOVERED, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_RECOVERED, 2'd3, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_REPORT, SUB_REPORT_MASK, 8'hFF, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd4, SID_CLEAR, GROUP_ALL, GROUP_ALL, 8'hFE);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_CLEAR, GROUP_ALL, GROUP_ALL, GROUP_ALL);
      send_item(OP_REQUEST, 2'd0, 16'd4, SID_CLEAR, GROUP_ALL, GROUP_ALL, GROUP_ALL);
      send_item(OP_REQUEST, 2'd0, 16'd1, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_item(OP_REQUEST, 2'd0, 16'd0, SID_SESSION, SESS_DEFAULT, 8'h00, 8'h00);
      send_item(OP_LOST, 2'd2, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_CLEAR, 2'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_REPORT, SUB_REPORT_ALL, 8'h00, 8'h00);
      wait_idle();
   endtask

   task automatic test_threshold_edges();
      req_gap_pct = 10;
      rsp_stall_pct = 10;
      // zero threshold confirms on the first loss
      configure(8'd0, 32'h0000_0000);
      send_item(OP_LOST, 2'd2, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_READ, ID_IDENT_HI, ID_IDENT_LO, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_REPORT, SUB_REPORT_ALL, 8'h00, 8'h00);
      wait_idle();
      configure(8'd1, 32'hFFFF_FFFF);
      send_item(OP_LOST, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_READ, ID_IDENT_HI, ID_IDENT_LO, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_REPORT, SUB_REPORT_MASK, ST_CONFIRMED, 8'h00);
      wait_idle();
      // confirm lands exactly on the count that reaches the threshold
      configure(8'd20, IDENT_RESET);
      req_gap_pct = 0;
      send_item(OP_CLEAR, 2'd0, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      repeat (19) send_item(OP_LOST, 2'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd3, SID_REPORT, SUB_REPORT_MASK, ST_CONFIRMED, 8'h00);
      repeat (3) send_item(OP_LOST, 2'd1, 16'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_item(OP_REQUEST, 2'd0, 16'd2, SID_REPORT, SUB_REPORT_ALL, 8'h00, 8'h00);
      wait_idle();
   endtask

   task automatic run_random(input int count, input int gap_pct, input int stall_pct);
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) random_item();
      wait_idle();
   endtask

   task automatic test_random_traffic();
      configure(8'($urandom_range(1, 6)), $urandom);
      run_random(50, 30, 30);
      configure(8'd1, 32'h0000_0000);
      run_random(40, 0, 0);
      configure(8'd255, 32'hFFFF_FFFF);
      run_random(40, 60, 60);
      configure(8'($urandom_range(2, 5)), $urandom);
      run_random(70, 20, 20);
   endtask

   // response check and receiver stalls
   always @(posedge clock) begin : resp_check
      resp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_resp.size() == 0) begin
            $display("%0t: response byte expected none, got %02h last %0b",
               $time, rsp_resp_byte, rsp_resp_last);
            mismatches++;
         end else begin
            want = pending_resp.pop_front();
            if (rsp_resp_byte !== want.data) begin
               $display("%0t: resp_byte expected %02h, got %02h",
                  $time, want.data, rsp_resp_byte);
               mismatches++;
            end
            if (rsp_resp_last !== want.last) begin
               $display("%0t: resp_last expected %0b, got %0b",
                  $time, want.last, rsp_resp_last);
               mismatches++;
            end
         end
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) stall_left = gap_length();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      wipe_faults();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_threshold_edges();
      test_random_traffic();
      if (mismatches == 0 && pending_resp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
